/* rtl/core/mlfq_pkg.sv */
// Shared types for the multilevel feedback queue scheduler.
// Holds command/result beats, controller states and control/status structs.
// No dependencies.
package mlfq_pkg;

    typedef enum logic [1:0] {
        MODE_ENQ     = 2'd0,
        MODE_DROP    = 2'd1,
        MODE_PREEMPT = 2'd2,
        MODE_YIELD   = 2'd3
    } t_mode;

    typedef logic [5:0] t_tid;

    typedef struct packed {
        t_mode mode;
        t_tid  thread_id;
    } t_cmd;

    typedef struct packed {
        logic       switch_valid;
        t_tid       next_thread;
        logic [3:0] next_level;
        logic       old_valid;
        t_tid       old_thread;
    } t_res;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PRIO_RD,
        S_APPEND,
        S_DEM_RD,
        S_DEMOTE,
        S_PICK,
        S_LINK
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic use_cur;
        logic dem_wr;
        logic append;
        logic pick;
        logic link_upd;
    } t_ctl;

    typedef struct packed {
        logic  clr_last;
        logic  tid_ok;
        t_mode mode;
        logic  cur_valid;
        logic  pick_found;
        logic  pick_single;
    } t_sts;

endpackage

/* rtl/core/mlfq_ctrl.sv */
// Controller FSM for the scheduler: sequences clear, append, demote and pick.
// Depends on mlfq_pkg.
module mlfq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_res_stb,
    input  mlfq_pkg::t_sts  i_sts,
    output mlfq_pkg::t_ctl  o_ctl
);

    mlfq_pkg::t_state r_state, n_state;
    logic             r_done;
    logic             n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlfq_pkg::S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        unique case (r_state)
            mlfq_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = mlfq_pkg::S_IDLE;
            end
            mlfq_pkg::S_IDLE: begin
                if (start && !r_done) begin
                    unique case (i_sts.mode)
                        mlfq_pkg::MODE_ENQ:     n_state = mlfq_pkg::S_APPEND;
                        mlfq_pkg::MODE_DROP:    n_state = mlfq_pkg::S_PRIO_RD;
                        mlfq_pkg::MODE_PREEMPT: n_state = mlfq_pkg::S_DEM_RD;
                        mlfq_pkg::MODE_YIELD:   n_state = mlfq_pkg::S_PICK;
                        default:                n_state = mlfq_pkg::S_PICK;
                    endcase
                end
            end
            mlfq_pkg::S_PRIO_RD: begin
                n_state = mlfq_pkg::S_APPEND;
            end
            mlfq_pkg::S_APPEND: begin
                n_state = mlfq_pkg::S_IDLE;
                n_done  = 1'b1;
            end
            mlfq_pkg::S_DEM_RD: begin
                n_state = mlfq_pkg::S_DEMOTE;
            end
            mlfq_pkg::S_DEMOTE: begin
                n_state = mlfq_pkg::S_PICK;
            end
            mlfq_pkg::S_PICK: begin
                if (i_sts.pick_found && !i_sts.pick_single) begin
                    n_state = mlfq_pkg::S_LINK;
                end else begin
                    n_state = mlfq_pkg::S_IDLE;
                    n_done  = 1'b1;
                end
            end
            mlfq_pkg::S_LINK: begin
                n_state = mlfq_pkg::S_IDLE;
                n_done  = 1'b1;
            end
            default: n_state = mlfq_pkg::S_CLEAR;
        endcase
    end

    // Note: mode is read from the incoming beat in IDLE (status carries latched mode
    // after load); the datapath forwards the live mode while idle.
    always_comb begin
        o_ctl     = '0;
        busy      = (r_state != mlfq_pkg::S_IDLE) || r_done;
        o_res_stb = r_done;
        unique case (r_state)
            mlfq_pkg::S_CLEAR:   o_ctl.clr_wr = 1'b1;
            mlfq_pkg::S_IDLE:    o_ctl.load = start && !r_done;
            mlfq_pkg::S_PRIO_RD: o_ctl.use_cur = 1'b0;
            mlfq_pkg::S_APPEND:  o_ctl.append = i_sts.tid_ok;
            mlfq_pkg::S_DEM_RD:  o_ctl.use_cur = 1'b1;
            mlfq_pkg::S_DEMOTE: begin
                o_ctl.use_cur = 1'b1;
                o_ctl.dem_wr  = i_sts.cur_valid;
            end
            mlfq_pkg::S_PICK:    o_ctl.pick = 1'b1;
            mlfq_pkg::S_LINK:    o_ctl.link_upd = 1'b1;
            default:             o_ctl = '0;
        endcase
    end

endmodule

/* rtl/core/mlfq_dp.sv */
// Datapath for the scheduler: queue ends, link and priority memories,
// current-thread and result registers. Depends on mlfq_pkg.
module mlfq_dp #(
    parameter int LEVELS      = 16,
    parameter int MAX_THREADS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mlfq_pkg::t_cmd  i_cmd,
    input  mlfq_pkg::t_ctl  i_ctl,
    output mlfq_pkg::t_sts  o_sts,
    output mlfq_pkg::t_res  o_res
);

    localparam int LW  = $clog2(LEVELS);
    localparam int TIW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

    mlfq_pkg::t_mode r_mode;
    mlfq_pkg::t_tid  r_tid;
    mlfq_pkg::t_tid  r_cur;
    logic            r_cur_valid;
    logic [TIW-1:0]  r_clr_cnt;
    logic [LEVELS-1:0] r_ne;
    mlfq_pkg::t_tid  r_head [LEVELS];
    mlfq_pkg::t_tid  r_tail [LEVELS];
    mlfq_pkg::t_tid  r_link_mem [MAX_THREADS];
    logic [LW-1:0]   r_prio_mem [MAX_THREADS];
    mlfq_pkg::t_tid  r_link_q;
    logic [LW-1:0]   r_prio_q;
    logic [LW-1:0]   r_pick_lvl;
    mlfq_pkg::t_res  r_res;

    logic [LEVELS-1:0] low_bit;
    logic [LW-1:0]     pick_lvl;
    mlfq_pkg::t_tid    pick_head;
    logic              pick_found;
    logic              pick_single;
    logic [LW-1:0]     app_lvl;
    logic [TIW-1:0]    prio_addr;
    logic [LW-1:0]     prio_wdata;
    logic              tid_ok;

    assign tid_ok = (11'(r_tid) < 11'(MAX_THREADS));

    always_comb begin
        low_bit  = r_ne & (~r_ne + LEVELS'(1));
        pick_lvl = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (low_bit[i]) pick_lvl = pick_lvl | LW'(i);
        end
    end

    assign pick_found  = |r_ne;
    assign pick_head   = r_head[pick_lvl];
    assign pick_single = (pick_head == r_tail[pick_lvl]);
    assign app_lvl     = (r_mode == mlfq_pkg::MODE_DROP) ? r_prio_q : '0;

    always_comb begin
        if (i_ctl.clr_wr) begin
            prio_addr = r_clr_cnt;
        end else if (i_ctl.use_cur) begin
            prio_addr = TIW'(r_cur);
        end else begin
            prio_addr = TIW'(r_tid);
        end
        prio_wdata = '0;
        if (!i_ctl.clr_wr && (r_prio_q < LW'(LEVELS - 1))) prio_wdata = r_prio_q + LW'(1);
        else if (!i_ctl.clr_wr) prio_wdata = r_prio_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr || i_ctl.dem_wr) r_prio_mem[prio_addr] <= prio_wdata;
        r_prio_q <= r_prio_mem[prio_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.append && r_ne[app_lvl]) r_link_mem[TIW'(r_tail[app_lvl])] <= r_tid;
        r_link_q <= r_link_mem[TIW'(pick_head)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne        <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_clr_cnt   <= '0;
        end else begin
            if (i_ctl.clr_wr) r_clr_cnt <= r_clr_cnt + TIW'(1);
            if (i_ctl.append) begin
                r_tail[app_lvl] <= r_tid;
                if (!r_ne[app_lvl]) begin
                    r_head[app_lvl] <= r_tid;
                    r_ne[app_lvl]   <= 1'b1;
                end
            end
            if (i_ctl.pick && pick_found) begin
                r_cur       <= pick_head;
                r_cur_valid <= 1'b1;
                r_pick_lvl  <= pick_lvl;
                if (pick_single) r_ne[pick_lvl] <= 1'b0;
            end
            if (i_ctl.link_upd) r_head[r_pick_lvl] <= r_link_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mode <= i_cmd.mode;
            r_tid  <= i_cmd.thread_id;
            r_res  <= '{switch_valid: 1'b0,
                        next_thread:  '0,
                        next_level:   '0,
                        old_valid:    i_cmd.mode[1] && r_cur_valid,
                        old_thread:   (i_cmd.mode[1] && r_cur_valid) ? r_cur : '0};
        end else if (i_ctl.pick && pick_found) begin
            r_res  <= '{switch_valid: 1'b1,
                        next_thread:  pick_head,
                        next_level:   4'(pick_lvl),
                        old_valid:    r_res.old_valid,
                        old_thread:   r_res.old_thread};
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.clr_last    = (32'(r_clr_cnt) == 32'(MAX_THREADS - 1));
        o_sts.tid_ok      = tid_ok;
        o_sts.mode        = i_ctl.load ? i_cmd.mode : r_mode;
        o_sts.cur_valid   = r_cur_valid;
        o_sts.pick_found  = pick_found;
        o_sts.pick_single = pick_single;
    end

    assign o_res = r_res;

endmodule

/* rtl/core/multilevel_feedback_queue_scheduler.sv */
// Multilevel feedback queue scheduler top level.
// Joins the controller (mlfq_ctrl) and datapath (mlfq_dp); uses mlfq_pkg.
//
// Usage:
//   Command channel: drive i_cmd and raise start; the beat is taken at a
//   rising edge with start high and busy low.
//   Result channel: o_res is valid for exactly one cycle with o_res_stb high.
//   Every command yields one result beat; there is no back-pressure.
// States after accept: enqueue APPEND (level 0); drop PRIO_RD, then APPEND
//   at the thread's stored level; yield PICK, then LINK when the picked level
//   held more than one thread; preempt DEM_RD, DEMOTE, PICK and LINK as for
//   yield (LINK takes the registered link read that advances the queue head).
//   busy also covers the strobe cycle, so a new command is taken at the
//   earliest in the cycle after the strobe, never before the last one is done.
// Reset: synchronous, active low. After reset the priority memory is cleared
//   one entry per cycle, all MAX_THREADS entries, with busy high; queues start
//   empty and no thread is current.
module multilevel_feedback_queue_scheduler #(
    parameter int LEVELS      = 16,
    parameter int MAX_THREADS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mlfq_pkg::t_cmd i_cmd,
    output logic           o_res_stb,
    output mlfq_pkg::t_res o_res
);

    mlfq_pkg::t_ctl ctl;
    mlfq_pkg::t_sts sts;

    mlfq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .o_res_stb (o_res_stb),
        .i_sts     (sts),
        .o_ctl     (ctl)
    );

    mlfq_dp #(
        .LEVELS      (LEVELS),
        .MAX_THREADS (MAX_THREADS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_res   (o_res)
    );

endmodule
